@@ hdl/irr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_pkg
// Shared types and constants of the integer ratio resampler.
// ----------------------------------------------------------------------------
package irr_pkg;

   localparam int MAX_FACTOR   = 16;
   localparam int MAX_OUTPUT   = 4096;
   localparam int SAMPLE_W     = 16;
   localparam int FACTOR_W     = 5;
   localparam int COUNT_W      = 13;
   localparam int PHASE_W      = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int QUEUE_CNT_W  = 2;

   typedef enum logic [1:0] {
      REG_DOWN_MODE    = 2'd0,
      REG_RATE_FACTOR  = 2'd1,
      REG_OUTPUT_LIMIT = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   // Effective configuration, already clamped to the supported range.
   typedef struct packed {
      logic                down_mode;
      logic [FACTOR_W-1:0] factor;
      logic [COUNT_W-1:0]  limit;
   } cfg_type;

   // One classified request waiting for the output sequencer.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [FACTOR_W-1:0]        copies;
      logic                       buffer_end;
   } entry_type;

endpackage

@@ hdl/irr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_front
// Accepts requests, tracks the decimation phase and decides how many
// output copies each request produces.
// ----------------------------------------------------------------------------
module irr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  irr_pkg::cfg_type                  cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic signed [irr_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              req_last,
   output logic                              push_valid,
   input  logic                              push_ready,
   output irr_pkg::entry_type                push_entry
);
   import irr_pkg::*;

   logic [PHASE_W-1:0]  phase_ff;
   logic [PHASE_W-1:0]  phase_in;
   logic [FACTOR_W-1:0] phase_inc;
   logic                accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid & push_ready;
   assign phase_inc  = {1'b0, phase_ff} + FACTOR_W'(1);

   always_comb begin
      push_entry.sample     = req_sample;
      push_entry.buffer_end = req_last;
      if (cfg.down_mode) begin
         push_entry.copies = (phase_ff == '0) ? FACTOR_W'(1) : '0;
      end else begin
         push_entry.copies = cfg.factor;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_last || !cfg.down_mode) begin
            phase_in = '0;
         end else if (phase_inc >= cfg.factor) begin
            // Also wraps a phase left beyond a factor lowered mid-buffer.
            phase_in = '0;
         end else begin
            phase_in = phase_inc[PHASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ hdl/irr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_queue
// Two-entry queue that decouples request classification from output
// sequencing.
// ----------------------------------------------------------------------------
module irr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  irr_pkg::entry_type push_entry,
   output logic               head_valid,
   input  logic               pop,
   output irr_pkg::entry_type head_entry
);
   import irr_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff;
   logic [QUEUE_CNT_W-1:0] fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (fill_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/irr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_back
// Output sequencer: emits head-entry copies one per cycle while the receiver
// is ready, keeps the per-buffer output count and drives the result register.
// ----------------------------------------------------------------------------
module irr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  irr_pkg::cfg_type                     cfg,
   input  logic                                 head_valid,
   input  irr_pkg::entry_type                   head_entry,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [irr_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                                 rsp_last,
   output logic [irr_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_full
);
   import irr_pkg::*;

   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;
   logic                       full_ff;
   logic                       full_in;
   logic [FACTOR_W-1:0]        sent_ff;
   logic [FACTOR_W-1:0]        sent_in;
   logic                       valid_ff;
   logic                       valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;
   logic [COUNT_W-1:0]         wcount_ff;
   logic                       reached_ff;

   logic [COUNT_W-1:0]  count_next;
   logic [FACTOR_W-1:0] sent_next;
   logic                advance;
   logic                can_emit;
   logic                hit_limit;
   logic                last_copy;
   logic                emit;
   logic                skip;

   assign count_next = count_ff + COUNT_W'(1);
   assign sent_next  = sent_ff + FACTOR_W'(1);
   assign advance    = !valid_ff || rsp_tready;
   assign can_emit   = (sent_ff < head_entry.copies) && !full_ff && (count_ff < cfg.limit);
   assign hit_limit  = (count_next == cfg.limit);
   assign last_copy  = (sent_next == head_entry.copies) || hit_limit;
   assign emit       = head_valid && can_emit && advance;
   // An entry with nothing left to give retires at once, even under stall.
   assign skip       = head_valid && !can_emit;
   assign pop        = skip || (emit && last_copy);

   always_comb begin
      count_in = count_ff;
      full_in  = full_ff;
      sent_in  = sent_ff;
      if (emit) begin
         count_in = count_next;
         full_in  = hit_limit;
         sent_in  = last_copy ? '0 : sent_next;
      end else if (skip) begin
         sent_in = '0;
      end
      if (pop && head_entry.buffer_end) begin
         count_in = '0;
         full_in  = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff  <= full_in;
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         sample_ff  <= head_entry.sample;
         last_ff    <= last_copy;
         wcount_ff  <= count_next;
         reached_ff <= hit_limit;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = last_ff;
   assign rsp_count  = wcount_ff;
   assign rsp_full   = reached_ff;

endmodule

@@ hdl/integer_ratio_resampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_ratio_resampler_core
// Integer-factor audio resampler: decimation or sample repetition with a
// per-buffer output limit.
// ----------------------------------------------------------------------------
// In down mode the core takes one request per clock while results are taken
// and passes every Nth sample; in up mode each request gives N copies (the
// clamped rate_factor), which the output sequencer emits one per cycle while
// the receiver is ready. A request that gives no result leaves the queue at
// once, even under stall, yet a stalled result still holds up the input once
// the queue is full. A two-entry queue between classification and sequencing
// lets the input keep flowing while a result waits in the output register.
// Program the registers only while the core is idle.
module integer_ratio_resampler_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   input  logic        req_tlast,   // buffer_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] sample_out, [28:16] written_count, zero
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // [0] limit_reached
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import irr_pkg::*;

   logic                down_mode_ff;
   logic [FACTOR_W-1:0] rate_factor_ff;
   logic [COUNT_W-1:0]  output_limit_ff;
   reg_index_type       reg_index;
   logic                csr_write;
   cfg_type             cfg;

   logic                       push_valid;
   logic                       push_ready;
   entry_type                  push_entry;
   logic                       head_valid;
   entry_type                  head_entry;
   logic                       pop;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic [COUNT_W-1:0]         rsp_count;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         down_mode_ff    <= 1'b0;
         rate_factor_ff  <= FACTOR_W'(1);
         output_limit_ff <= COUNT_W'(MAX_OUTPUT);
      end else if (csr_write) begin
         case (reg_index)
            REG_DOWN_MODE:    down_mode_ff    <= csr_pwdata[0];
            REG_RATE_FACTOR:  rate_factor_ff  <= csr_pwdata[FACTOR_W-1:0];
            REG_OUTPUT_LIMIT: output_limit_ff <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DOWN_MODE:    csr_prdata = {31'd0, down_mode_ff};
         REG_RATE_FACTOR:  csr_prdata = {{(32-FACTOR_W){1'b0}}, rate_factor_ff};
         REG_OUTPUT_LIMIT: csr_prdata = {{(32-COUNT_W){1'b0}}, output_limit_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp the factor to 1..MAX_FACTOR and the limit to MAX_OUTPUT.
   always_comb begin
      cfg.down_mode = down_mode_ff;
      if (rate_factor_ff == '0) begin
         cfg.factor = FACTOR_W'(1);
      end else if (rate_factor_ff > FACTOR_W'(MAX_FACTOR)) begin
         cfg.factor = FACTOR_W'(MAX_FACTOR);
      end else begin
         cfg.factor = rate_factor_ff;
      end
      if (output_limit_ff > COUNT_W'(MAX_OUTPUT)) begin
         cfg.limit = COUNT_W'(MAX_OUTPUT);
      end else begin
         cfg.limit = output_limit_ff;
      end
   end

   irr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .req_last   (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   irr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   irr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_tlast),
      .rsp_count  (rsp_count),
      .rsp_full   (rsp_tuser)
   );

   assign rsp_tdata = {{(32-SAMPLE_W-COUNT_W){1'b0}}, rsp_count, rsp_sample};

endmodule

@@ sim/tb_integer_ratio_resampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_ratio_resampler_core
// Self-checking bench for the integer ratio resampler. Requests are fed from
// a queue by a clocked driver, an in-bench resampling model predicts every
// output sample, and a clocked monitor compares each result against it.
// Directed buffers cover the corner cases; random buffers follow under
// random configurations, random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_integer_ratio_resampler_core;
   import irr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [15:0] sample;
      logic        buffer_end;
   } sample_req_type;

   typedef struct packed {
      logic [15:0]        sample;
      logic               run_last;
      logic [COUNT_W-1:0] count;
      logic               reached;
   } resample_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sample_req_type   sample_feed[$];
   resample_out_type pending_outputs[$];
   sample_req_type   feed_item;
   resample_out_type got;
   resample_out_type want;

   int issued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   logic req_fired    = 1'b0;
   logic steady       = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;

   // Model of the block: configuration as written, plus per-buffer state.
   logic               mdl_down   = 1'b0;
   logic [FACTOR_W-1:0] mdl_factor = 5'd1;
   logic [COUNT_W-1:0] mdl_limit  = 13'd4096;
   logic [PHASE_W-1:0] mdl_phase  = '0;
   logic [COUNT_W-1:0] mdl_count  = '0;
   logic               mdl_full   = 1'b0;

   integer_ratio_resampler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Works out the output samples one request causes and queues them.
   task automatic resample_predict(input logic [15:0] s, input logic buf_end);
      int factor;
      int limit;
      int copies;
      int k;
      resample_out_type r;
      factor = (mdl_factor == 0) ? 1 : ((mdl_factor > MAX_FACTOR) ? MAX_FACTOR : mdl_factor);
      limit  = (mdl_limit > MAX_OUTPUT) ? MAX_OUTPUT : mdl_limit;
      if (mdl_down) begin
         copies = (mdl_phase == 0) ? 1 : 0;
         if (int'(mdl_phase) + 1 >= factor) begin
            mdl_phase = '0;
         end else begin
            mdl_phase = mdl_phase + 1'b1;
         end
      end else begin
         copies = factor;
         mdl_phase = '0;
      end
      k = 0;
      while (k < copies && !mdl_full && mdl_count < limit) begin
         mdl_count = mdl_count + 1'b1;
         r.sample = s;
         r.count = mdl_count;
         r.reached = (mdl_count == limit);
         // A run cut by the limit ends on the copy that filled the buffer.
         r.run_last = (k == copies - 1) || r.reached;
         if (r.reached) begin
            mdl_full = 1'b1;
         end
         pending_outputs.push_back(r);
         k++;
      end
      if (buf_end) begin
         mdl_phase = '0;
         mdl_count = '0;
         mdl_full = 1'b0;
      end
   endtask

   // Monitor: tracks register writes and accepted requests, checks results.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_DOWN_MODE:    mdl_down   = csr_pwdata[0];
               REG_RATE_FACTOR:  mdl_factor = csr_pwdata[FACTOR_W-1:0];
               REG_OUTPUT_LIMIT: mdl_limit  = csr_pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            resample_predict(req_tdata, req_tlast);
            accepted_count = accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sample = rsp_tdata[15:0];
            got.count = rsp_tdata[28:16];
            got.run_last = rsp_tlast;
            got.reached = rsp_tuser;
            if (pending_outputs.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected output: sample %h count %0d last %b full %b",
                           got.sample, got.count, got.run_last, got.reached);
               end
            end else begin
               want = pending_outputs.pop_front();
               if (got != want || rsp_tdata[31:29] != 3'b000) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display({"output mismatch: expected sample %h count %0d last %b",
                               " full %b, got tdata %h last %b full %b"},
                              want.sample, want.count, want.run_last, want.reached,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  end
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Request driver: holds a request until it is taken, then maybe idles.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (sample_feed.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
            feed_item = sample_feed.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= feed_item.sample;
            req_tlast <= feed_item.buffer_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random back-pressure and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 36);
      end
   end

   task automatic queue_sample(input logic [15:0] s, input logic buf_end);
      sample_req_type q;
      q.sample = s;
      q.buffer_end = buf_end;
      sample_feed.push_back(q);
      issued_count++;
   endtask

   // Ends on a rising edge so that requests queued next are seen by the driver.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every request is taken and every output has arrived, then
   // lets the block finish any request that causes no output.
   task automatic settle;
      do @(negedge clock);
      while (!(accepted_count == issued_count && pending_outputs.size() == 0));
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic random_setup;
      int r;
      logic [31:0] factor;
      logic [31:0] limit;
      r = $urandom_range(9);
      case (r)
         0: factor = 0;
         1: factor = 31;
         2: factor = MAX_FACTOR;
         3: factor = $urandom_range(17, 31);
         default: factor = $urandom_range(1, 6);
      endcase
      r = $urandom_range(9);
      case (r)
         0: limit = 0;
         1: limit = 8191;
         2: limit = MAX_OUTPUT;
         3, 4, 5: limit = $urandom_range(1, 30);
         default: limit = $urandom_range(31, 8191);
      endcase
      csr_write(REG_DOWN_MODE, $urandom_range(1));
      csr_write(REG_RATE_FACTOR, factor);
      csr_write(REG_OUTPUT_LIMIT, limit);
   endtask

   // Mostly whole buffers that end on their last sample; now and then a
   // buffer with end marks scattered at random.
   task automatic feed_random(input int n);
      int left;
      int len;
      int i;
      logic noisy;
      logic buf_end;
      logic [15:0] s;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         if (len > left) begin
            len = left;
         end
         noisy = ($urandom_range(9) == 0);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(7))
               0: s = 16'h8000;
               1: s = 16'h7FFF;
               default: s = $urandom;
            endcase
            buf_end = noisy ? 1'($urandom_range(1)) : (i == len - 1);
            queue_sample(s, buf_end);
         end
         left -= len;
      end
   endtask

   initial begin
      int p;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: one copy per sample, full limit.
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h7FFF, 1'b1);
      settle;

      // Largest factor, and a limit above the supported maximum.
      csr_write(REG_RATE_FACTOR, MAX_FACTOR);
      csr_write(REG_OUTPUT_LIMIT, 8191);
      queue_sample(16'h1234, 1'b0);
      queue_sample(16'h8001, 1'b1);
      settle;

      // A zero factor acts as one, a factor above the maximum saturates.
      csr_write(REG_RATE_FACTOR, 0);
      queue_sample(16'h0F0F, 1'b1);
      settle;
      csr_write(REG_RATE_FACTOR, 31);
      queue_sample(16'hF0F0, 1'b1);
      settle;

      // A zero limit gives no output at all.
      csr_write(REG_RATE_FACTOR, 3);
      csr_write(REG_OUTPUT_LIMIT, 0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h0002, 1'b1);
      settle;

      // The limit cuts the second run short; the third sample gives nothing.
      csr_write(REG_OUTPUT_LIMIT, 5);
      queue_sample(16'h1111, 1'b0);
      queue_sample(16'h2222, 1'b0);
      queue_sample(16'h3333, 1'b1);
      settle;

      // The limit is lowered below the running count in mid-buffer.
      csr_write(REG_RATE_FACTOR, 4);
      csr_write(REG_OUTPUT_LIMIT, 100);
      queue_sample(16'h4444, 1'b0);
      queue_sample(16'h5555, 1'b0);
      queue_sample(16'hAAAA, 1'b0);
      settle;
      csr_write(REG_OUTPUT_LIMIT, 8);
      queue_sample(16'h6666, 1'b0);
      queue_sample(16'h7777, 1'b1);
      settle;

      // Decimation by four over one buffer.
      csr_write(REG_DOWN_MODE, 1);
      csr_write(REG_OUTPUT_LIMIT, MAX_OUTPUT);
      queue_sample(16'h0100, 1'b0);
      queue_sample(16'h0200, 1'b0);
      queue_sample(16'h0300, 1'b0);
      queue_sample(16'h0400, 1'b0);
      queue_sample(16'h0500, 1'b1);
      settle;

      // The factor shrinks below the phase in mid-buffer, so the phase wraps.
      csr_write(REG_RATE_FACTOR, 8);
      queue_sample(16'h0A00, 1'b0);
      queue_sample(16'h0B00, 1'b0);
      queue_sample(16'h0C00, 1'b0);
      settle;
      csr_write(REG_RATE_FACTOR, 2);
      queue_sample(16'h0D00, 1'b0);
      queue_sample(16'h0E00, 1'b1);
      settle;

      for (p = 0; p < 8; p++) begin
         random_setup;
         steady = (p == 2);
         feed_random(20);
         settle;
         steady = 1'b0;
      end

      // The receiver stalls for a long time while the sender keeps offering.
      csr_write(REG_DOWN_MODE, 0);
      csr_write(REG_RATE_FACTOR, 12);
      csr_write(REG_OUTPUT_LIMIT, MAX_OUTPUT);
      hold_request = 1'b1;
      feed_random(20);
      settle;
      hold_request = 1'b0;

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
